FILE: src/u8d_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 stream decoder.
// It has no dependencies. The front end, the queue, the back end and the top level import it.
package u8d_pkg;

    localparam int CP_W       = 21;
    localparam int BYTE_W     = 8;
    localparam int M_TDATA_W  = 24;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            inv;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam t_result RES_INVALID = '{cp: '0, inv: 1'b1};

endpackage

FILE: src/u8d_front.sv
`timescale 1ns / 1ps
// Front end: accepts input bytes, tracks the open run and forms the results of each byte.
// It depends on u8d_pkg and writes one queue entry for each byte that yields a result.
module u8d_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tlast,
    input  u8d_pkg::t_q_status i_q,
    output logic               o_push,
    output u8d_pkg::t_entry    o_entry
);
    import u8d_pkg::*;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } t_class;

    logic [1:0]      r_pend;
    logic [1:0]      n_pend;
    logic [CP_W-1:0] r_pc;
    logic [CP_W-1:0] n_pc;
    t_class          cls;
    logic            accept;
    logic [1:0]      dec;
    logic [CP_W-1:0] merged;
    logic [CP_W-1:0] cont_bits;
    logic            has_a;
    logic            has_b;
    logic            has_c;
    t_result         res_b;

    always_comb begin
        if (s_tdata[7] == 1'b0) begin
            cls = CLS_ASCII;
        end else if (s_tdata[7:6] == 2'b10) begin
            cls = CLS_CONT;
        end else if (s_tdata[7:5] == 3'b110) begin
            cls = CLS_LEAD2;
        end else if (s_tdata[7:4] == 4'b1110) begin
            cls = CLS_LEAD3;
        end else if (s_tdata[7:3] == 5'b11110) begin
            cls = CLS_LEAD4;
        end else begin
            cls = CLS_BAD;
        end
    end

    always_comb begin
        accept    = s_tvalid && !i_q.full;
        dec       = r_pend - 2'd1;
        cont_bits = {{(CP_W-6){1'b0}}, s_tdata[5:0]};
        case (dec)
            2'd1:    merged = r_pc | (cont_bits << 6);
            2'd2:    merged = r_pc | (cont_bits << 12);
            default: merged = r_pc | cont_bits;
        endcase
        n_pend = r_pend;
        n_pc   = r_pc;
        has_a  = 1'b0;
        has_b  = 1'b0;
        has_c  = 1'b0;
        res_b  = RES_INVALID;
        if (r_pend != 2'd0 && cls == CLS_CONT) begin
            n_pend = dec;
            n_pc   = merged;
            if (dec == 2'd0) begin
                has_b = 1'b1;
                res_b = '{cp: merged, inv: 1'b0};
            end else if (s_tlast) begin
                has_c = 1'b1;
            end
        end else begin
            has_a  = (r_pend != 2'd0);
            n_pend = 2'd0;
            n_pc   = '0;
            case (cls)
                CLS_ASCII: begin
                    has_b = 1'b1;
                    res_b = '{cp: {{(CP_W-7){1'b0}}, s_tdata[6:0]}, inv: 1'b0};
                end
                CLS_LEAD2: begin
                    n_pend = 2'd1;
                    n_pc   = {{(CP_W-11){1'b0}}, s_tdata[4:0], 6'd0};
                end
                CLS_LEAD3: begin
                    n_pend = 2'd2;
                    n_pc   = {{(CP_W-16){1'b0}}, s_tdata[3:0], 12'd0};
                end
                CLS_LEAD4: begin
                    n_pend = 2'd3;
                    n_pc   = {s_tdata[2:0], 18'd0};
                end
                default: begin
                    has_b = 1'b1;
                end
            endcase
            has_c = s_tlast && (n_pend != 2'd0);
        end
        if (s_tlast) begin
            n_pend = 2'd0;
            n_pc   = '0;
        end
    end

    always_comb begin
        s_tready      = !i_q.full;
        o_push        = accept && (has_a || has_b || has_c);
        o_entry.two   = has_a && (has_b || has_c);
        o_entry.r0    = has_a ? RES_INVALID : (has_b ? res_b : RES_INVALID);
        o_entry.r1    = has_b ? res_b : RES_INVALID;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_pc   <= '0;
        end else if (accept) begin
            r_pend <= n_pend;
            r_pc   <= n_pc;
        end
    end

endmodule

FILE: src/u8d_queue.sv
`timescale 1ns / 1ps
// Short queue of result entries between the front end and the back end.
// It depends on u8d_pkg for the entry and status types.
module u8d_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u8d_pkg::t_entry    i_entry,
    input  logic               i_pop,
    output u8d_pkg::t_entry    o_head,
    output u8d_pkg::t_q_status o_status
);
    import u8d_pkg::*;

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_count;
    logic [Q_CW-1:0] n_count;

    always_comb begin
        o_head         = r_mem[r_rp];
        o_status.full  = (r_count == Q_CW'(Q_DEPTH));
        o_status.empty = (r_count == '0);
        n_count        = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("Queue written while full.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("Queue read while empty.");

endmodule

FILE: src/u8d_back.sv
`timescale 1ns / 1ps
// Back end: walks the results of each queue entry and holds the output word register.
// It depends on u8d_pkg for the entry and status types.
module u8d_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  u8d_pkg::t_entry                    i_head,
    input  u8d_pkg::t_q_status                 i_q,
    output logic                               o_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [u8d_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import u8d_pkg::*;

    logic            r_sel;
    logic            n_sel;
    logic            r_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_inv;
    logic            r_last;
    logic            load;
    logic            take;
    logic            is_final;
    t_result         cur;

    always_comb begin
        load     = !r_valid || m_tready;
        take     = load && !i_q.empty;
        cur      = r_sel ? i_head.r1 : i_head.r0;
        is_final = r_sel || !i_head.two;
        o_pop    = take && is_final;
        n_sel    = r_sel;
        if (take) begin
            n_sel = !is_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_sel <= n_sel;
            if (load) begin
                r_valid <= take;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cp   <= cur.cp;
            r_inv  <= cur.inv;
            r_last <= is_final;
        end
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = {{(M_TDATA_W-CP_W){1'b0}}, r_cp};
    assign m_tuser  = r_inv;
    assign m_tlast  = r_last;

    a_sel_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> !i_q.empty)
        else $error("Second result selected with no entry at the head.");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("Invalid word carries a nonzero code point.");

endmodule

FILE: src/utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the UTF-8 stream decoder: front end, entry queue and back end.
// It depends on u8d_pkg, u8d_front, u8d_queue and u8d_back.
//
// channel  | direction | tdata                          | tuser       | tlast
// s_*      | in        | [7:0] data_byte                | none        | end_of_stream
// m_*      | out       | [20:0] code_point, zero filled | [0] invalid | last_of_run
//
// One input word is accepted every cycle while the queue has room.
// A word yields zero, one or two output words; the output register sends one word per cycle
// while m_tready is high, so a word with two results leaves as two output words.
// A result reaches the output through the queue and then the output register.
// Reset is synchronous and closes any open run; a stalled output only stops input once
// the four-entry queue is full.
module utf8_stream_decoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [u8d_pkg::M_TDATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic                          m_tuser,   // [0] invalid
    output logic                          m_tlast
);
    import u8d_pkg::*;

    logic      push;
    logic      pop;
    t_entry    entry;
    t_entry    head;
    t_q_status q_status;

    u8d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .i_q      (q_status),
        .o_push   (push),
        .o_entry  (entry)
    );

    u8d_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    u8d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q      (q_status),
        .o_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for utf8_stream_decoder_unit: directed byte table, then random UTF-8 text.
// Depends on u8d_pkg and the decoder RTL; typed rows or a behavioral decoder give expected words.
module tb;

    import u8d_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int RST_CYCLES = 11;
    localparam int N_RANDOM   = 550;
    localparam int N_DIRECTED = 25;
    localparam int MAX_REPORT = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT = 20;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            inv;
        logic            last;
    } cp_word_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eos;
        logic       typed;
        logic [1:0] n;
        cp_word_t   r0;
        cp_word_t   r1;
    } byte_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

    typedef enum int {GEN_CHAR, GEN_NOISE, GEN_TRUNC, GEN_BAD} gen_kind_t;

    localparam cp_word_t NO_WORD  = '0;
    localparam cp_word_t BAD_LAST = '{cp: '0, inv: 1'b1, last: 1'b1};
    localparam cp_word_t BAD_MID  = '{cp: '0, inv: 1'b1, last: 1'b0};

    localparam byte_row_t DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, 2'd1, '{21'h000000, 1'b0, 1'b1}, NO_WORD},
        '{8'h7F, 1'b0, 1'b1, 2'd1, '{21'h00007F, 1'b0, 1'b1}, NO_WORD},
        '{8'h80, 1'b0, 1'b1, 2'd1, BAD_LAST, NO_WORD},
        '{8'hBF, 1'b0, 1'b1, 2'd1, BAD_LAST, NO_WORD},
        '{8'hF8, 1'b0, 1'b1, 2'd1, BAD_LAST, NO_WORD},
        '{8'hFF, 1'b1, 1'b1, 2'd1, BAD_LAST, NO_WORD},
        '{8'hC2, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hA9, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hE2, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h82, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hAC, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hF7, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hBF, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hBF, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hBF, 1'b0, 1'b1, 2'd1, '{21'h1FFFFF, 1'b0, 1'b1}, NO_WORD},
        '{8'hC0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h80, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hE0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h41, 1'b0, 1'b1, 2'd2, BAD_MID, '{21'h000041, 1'b0, 1'b1}},
        '{8'hF0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h90, 1'b1, 1'b1, 2'd1, BAD_LAST, NO_WORD},
        '{8'hC3, 1'b1, 1'b1, 2'd1, BAD_LAST, NO_WORD},
        '{8'hE1, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hC3, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hA9, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;     // [7:0] data_byte
    logic                 s_tlast = 1'b0;   // end_of_stream
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [20:0] code_point, [23:21] zero
    logic                 m_tuser;          // [0] invalid
    logic                 m_tlast;          // last_of_run

    cp_word_t   expect_q [$];
    byte_row_t  text_q [$];
    logic [1:0] cont_left = '0;
    logic [CP_W-1:0] cp_acc = '0;
    int         burst_left = 0;
    int         mismatches = 0;
    int         words_sent = 0;
    int         words_checked = 0;
    int         invalid_seen = 0;
    int         eos_sent = 0;
    int         cycle_cnt = 0;
    int         rx_left = 0;
    rx_mode_t   rx_mode = RX_OPEN;

    utf8_stream_decoder_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("utf8_stream_decoder_unit test failed");
            $finish;
        end
    end

    function automatic void decode_byte(input logic [7:0] b, input logic eos,
                                        output cp_word_t [1:0] res, output int n);
        logic taken;
        res   = '0;
        n     = 0;
        taken = 1'b0;
        if (cont_left != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                taken     = 1'b1;
                cont_left = cont_left - 2'd1;
                cp_acc    = cp_acc | (CP_W'(b[5:0]) << (6 * cont_left));
                if (cont_left == 2'd0) begin
                    res[n] = '{cp: cp_acc, inv: 1'b0, last: 1'b0};
                    n++;
                end else if (eos) begin
                    res[n] = BAD_MID;
                    n++;
                end
            end else begin
                res[n] = BAD_MID;
                n++;
                cont_left = 2'd0;
                cp_acc    = '0;
            end
        end
        if (!taken) begin
            casez (b)
                8'b0???????: begin
                    res[n] = '{cp: CP_W'(b[6:0]), inv: 1'b0, last: 1'b0};
                    n++;
                end
                8'b110?????: begin
                    cont_left = 2'd1;
                    cp_acc    = CP_W'(b[4:0]) << 6;
                end
                8'b1110????: begin
                    cont_left = 2'd2;
                    cp_acc    = CP_W'(b[3:0]) << 12;
                end
                8'b11110???: begin
                    cont_left = 2'd3;
                    cp_acc    = CP_W'(b[2:0]) << 18;
                end
                default: begin
                    res[n] = BAD_MID;
                    n++;
                end
            endcase
            if (eos && cont_left != 2'd0) begin
                res[n] = BAD_MID;
                n++;
            end
        end
        if (eos) begin
            cont_left = 2'd0;
            cp_acc    = '0;
        end
        if (n > 0) begin
            res[n-1].last = 1'b1;
        end
    endfunction

    task automatic send_byte(input byte_row_t row);
        cp_word_t [1:0] res;
        int n;
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= row.b;
        s_tlast  <= row.eos;
        do @(posedge i_clk); while (!s_tready);
        decode_byte(row.b, row.eos, res, n);
        if (row.typed) begin
            n      = row.n;
            res[0] = row.r0;
            res[1] = row.r1;
        end
        for (int i = 0; i < n; i++) begin
            expect_q.push_back(res[i]);
        end
        words_sent++;
        if (row.eos) begin
            eos_sent++;
        end
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic build_text();
        byte_row_t row;
        gen_kind_t kind;
        int len;
        int sel;
        logic [7:0] seq [4];
        while (text_q.size() < N_RANDOM) begin
            sel = $urandom_range(0, 9);
            kind = (sel < 7) ? GEN_CHAR : (sel == 7) ? GEN_NOISE : (sel == 8) ? GEN_TRUNC : GEN_BAD;
            len = $urandom_range(1, 4);
            for (int i = 1; i < 4; i++) begin
                seq[i] = {2'b10, 6'($urandom_range(0, 63))};
            end
            case (len)
                1: seq[0] = {1'b0, 7'($urandom_range(0, 127))};
                2: seq[0] = {3'b110, 5'($urandom_range(0, 31))};
                3: seq[0] = {4'b1110, 4'($urandom_range(0, 15))};
                default: seq[0] = {5'b11110, 3'($urandom_range(0, 7))};
            endcase
            case (kind)
                GEN_NOISE: begin
                    seq[0] = 8'($urandom_range(0, 255));
                    len    = 1;
                end
                GEN_TRUNC: begin
                    if (len > 1) begin
                        len = $urandom_range(1, len - 1);
                    end
                end
                GEN_BAD: begin
                    seq[0] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'hF8, 8'hFF))
                                                         : seq[1];
                    len    = 1;
                end
                default: ;
            endcase
            for (int i = 0; i < len; i++) begin
                row     = '0;
                row.b   = seq[i];
                row.eos = ($urandom_range(0, 24) == 0);
                text_q.push_back(row);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 80);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
            default:  m_tready <= ((cycle_cnt % 5) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        cp_word_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            words_checked++;
            if (m_tuser) begin
                invalid_seen++;
            end
            if (expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORT) begin
                    $display("unexpected word: tdata=%h tuser=%b tlast=%b",
                             m_tdata, m_tuser, m_tlast);
                end
            end else begin
                want = expect_q.pop_front();
                if (m_tdata !== M_TDATA_W'(want.cp) || m_tuser !== want.inv ||
                    m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT) begin
                        $display("mismatch: expected cp=%h inv=%b last=%b, got tdata=%h tuser=%b tlast=%b",
                                 want.cp, want.inv, want.last, m_tdata, m_tuser, m_tlast);
                    end
                end
            end
        end
    end

    initial begin
        build_text();
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_byte(DIRECTED[i]);
        end
        hold_until_drained();
        for (int i = 0; i < text_q.size(); i++) begin
            if (i == text_q.size() / 2) begin
                hold_until_drained();
            end
            send_byte(text_q[i]);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        mismatches += expect_q.size();
        $display("Sent %0d bytes (%0d ending a stream) and checked %0d code point words, %0d invalid.",
                 words_sent, eos_sent, words_checked, invalid_seen);
        $display("Mismatches: %0d.", mismatches);
        if (mismatches == 0) begin
            $display("utf8_stream_decoder_unit test passed");
        end else begin
            $display("utf8_stream_decoder_unit test failed");
        end
        $finish;
    end

endmodule
